// File: hw/rtl/auf_pkg.sv
package auf_pkg;

    localparam int BLOCK_SAMPLES = 256;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = $clog2(BLOCK_SAMPLES);
    localparam int FRAMES_W      = $clog2(BLOCK_SAMPLES / 2 + 1);
    localparam int MAG_W         = SAMPLE_W + 1;
    localparam int NUM_W         = MAG_W + FRAMES_W;
    localparam int CNT_W         = $clog2(NUM_W);

    typedef struct packed {
        logic load;
        logic start;
        logic mul;
        logic div_step;
        logic commit;
    } auf_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } auf_status_t;

endpackage

// File: hw/rtl/auf_ctrl.sv
module auf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  auf_pkg::auf_status_t status,
    output auf_pkg::auf_cmd_t    cmd
);
    import auf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("word overwritten in output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_START))
        else $error("accepted word not started");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && status.div_last) |=> (state_reg == S_DONE))
        else $error("divide did not finish");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("output valid without commit");

endmodule

// File: hw/rtl/auf_datapath.sv
module auf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [auf_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic                          in_supplied,
    input  auf_pkg::auf_cmd_t             cmd,
    output auf_pkg::auf_status_t          status,
    output logic [auf_pkg::SAMPLE_W-1:0]  out_sample,
    output logic                          out_fade,
    output logic                          out_last
);
    import auf_pkg::*;

    logic                running_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                fading_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [POS_W-1:0]    offset_reg;
    logic [SAMPLE_W-1:0] held_l_reg;
    logic [SAMPLE_W-1:0] held_r_reg;
    logic [SAMPLE_W-1:0] pending_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                supplied_reg;
    logic                need_div_reg;
    logic                neg_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [FRAMES_W-1:0] rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_fade_reg;
    logic                out_last_reg;

    logic [POS_W:0]      remain;
    logic                in_range;
    logic [SAMPLE_W-1:0] base;
    logic [MAG_W-1:0]    base_ext;
    logic [MAG_W-1:0]    mag;
    logic [FRAMES_W-1:0] weight;
    logic [FRAMES_W:0]   rem_sh;
    logic                ge;
    logic [FRAMES_W:0]   rem_new;
    logic [MAG_W-1:0]    q_mag;
    logic [MAG_W-1:0]    q_signed;
    logic [SAMPLE_W-1:0] value;
    logic                is_last;

    assign remain   = (POS_W + 1)'(BLOCK_SAMPLES) - {1'b0, pos_reg};
    assign in_range = ((POS_W + 1)'(offset_reg) < (POS_W + 1)'({frames_reg, 1'b0}))
                      && (frames_reg != '0);
    assign base     = offset_reg[0] ? held_r_reg : held_l_reg;
    assign base_ext = {base[SAMPLE_W-1], base};
    assign mag      = base[SAMPLE_W-1] ? (~base_ext + 1'b1) : base_ext;
    assign weight   = frames_reg - FRAMES_W'(offset_reg >> 1);

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, frames_reg};
    assign rem_new  = ge ? (rem_sh - {1'b0, frames_reg}) : rem_sh;

    assign q_mag    = num_reg[MAG_W-1:0];
    assign q_signed = neg_reg ? (~q_mag + 1'b1) : q_mag;

    assign is_last  = (pos_reg == POS_W'(BLOCK_SAMPLES - 1));

    always_comb begin
        if (fading_reg) begin
            value = need_div_reg ? q_signed[SAMPLE_W-1:0] : '0;
        end else begin
            value = sample_reg;
        end
    end

    assign status.need_div = running_reg && fading_reg && in_range;
    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg   <= in_sample;
            supplied_reg <= in_supplied;
        end
        if (cmd.mul) begin
            need_div_reg <= status.need_div;
            neg_reg      <= base[SAMPLE_W-1];
            num_reg      <= NUM_W'(mag) * NUM_W'(weight);
            rem_reg      <= '0;
            cnt_reg      <= CNT_W'(NUM_W - 1);
        end
        if (cmd.div_step) begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= rem_new[FRAMES_W-1:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (running_reg) begin
                out_sample_reg <= value;
                out_fade_reg   <= fading_reg;
                out_last_reg   <= is_last;
            end else begin
                out_sample_reg <= '0;
                out_fade_reg   <= 1'b0;
                out_last_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pos_reg     <= '0;
            fading_reg  <= 1'b0;
            frames_reg  <= '0;
            offset_reg  <= '0;
            held_l_reg  <= '0;
            held_r_reg  <= '0;
            pending_reg <= '0;
        end else begin
            if (cmd.start && running_reg && !fading_reg && !supplied_reg) begin
                fading_reg <= 1'b1;
                frames_reg <= FRAMES_W'(remain >> 1);
                offset_reg <= '0;
            end
            if (cmd.commit) begin
                if (!running_reg) begin
                    pos_reg     <= '0;
                    fading_reg  <= 1'b0;
                    frames_reg  <= '0;
                    offset_reg  <= '0;
                    held_l_reg  <= '0;
                    held_r_reg  <= '0;
                    pending_reg <= '0;
                end else if (is_last) begin
                    held_l_reg  <= pending_reg;
                    held_r_reg  <= value;
                    pos_reg     <= '0;
                    fading_reg  <= 1'b0;
                    frames_reg  <= '0;
                    offset_reg  <= '0;
                    pending_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                    if (fading_reg) begin
                        offset_reg <= offset_reg + 1'b1;
                    end
                    if (pos_reg == POS_W'(BLOCK_SAMPLES - 2)) begin
                        pending_reg <= value;
                    end
                end
            end
            if (cfg_we) begin
                running_reg <= cfg_wdata;
                if (!cfg_wdata) begin
                    pos_reg     <= '0;
                    fading_reg  <= 1'b0;
                    frames_reg  <= '0;
                    offset_reg  <= '0;
                    held_l_reg  <= '0;
                    held_r_reg  <= '0;
                    pending_reg <= '0;
                end
            end
        end
    end

    assign out_sample = out_sample_reg;
    assign out_fade   = out_fade_reg;
    assign out_last   = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && running_reg && is_last) |=> (pos_reg == '0 && !fading_reg))
        else $error("block end did not restart position");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_we && !cfg_wdata) |=> (held_l_reg == '0 && held_r_reg == '0 && !fading_reg))
        else $error("stop did not clear history");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fading_reg |-> ((POS_W + 1)'(offset_reg) <= remain + (POS_W + 1)'(pos_reg)))
        else $error("fade offset beyond block");

endmodule

// File: hw/rtl/audio_underrun_fade_out_top.sv
// Stereo underrun fade-out for fixed-length transmit blocks. Each input word carries one
// interleaved slot and a tuser flag that is 1 when the pipeline supplied it; from the first
// missing slot to the block end, input data is dropped and a linear fade from the last
// left/right pair of the previous block toward zero is sent instead, with m_tuser high and
// m_tlast on the final slot of each block. The block comes out of reset stopped: write
// cfg_wdata = 1 (with cfg_we) to run, and write it only while no word is in flight. Clear
// cfg_wdata (with cfg_we) to stop: output goes to zero and history clears. Each slot steps
// through load, start, multiply and commit; when a fade value is computed, a divide phase
// runs between multiply and commit, in which the restoring divider produces one quotient
// bit per cycle. A slot also waits for as long as the previous word sits unaccepted in the
// output register. A finished word waits in the output register while the next slot is
// accepted and processed.
module audio_underrun_fade_out_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    input  logic        s_tuser,   // [0] from_pipeline
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tuser,   // [0] is_fade
    output logic        m_tlast
);
    import auf_pkg::*;

    auf_cmd_t    cmd;
    auf_status_t status;

    auf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    auf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_sample   (s_tdata),
        .in_supplied (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .out_sample  (m_tdata),
        .out_fade    (m_tuser),
        .out_last    (m_tlast)
    );

endmodule

// File: dv/audio_underrun_fade_out_top_tb.sv
module audio_underrun_fade_out_top_tb;

    localparam int SLOTS         = auf_pkg::BLOCK_SAMPLES;
    localparam int PHASE_WORDS   = 400;
    localparam int STOPPED_WORDS = 6;
    localparam int HOLD_AFTER    = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 80;
    localparam int STUCK_LIMIT   = 5000;
    localparam int MAX_PRINTS    = 20;

    typedef enum logic {ROW_WORD, ROW_RUN} row_kind_e;
    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [15:0] sample;
        logic        fade;
        logic        last;
    } slot_out_t;

    typedef struct packed {
        row_kind_e   kind;
        logic [15:0] data;
        logic        user;
        logic        typed;
        slot_out_t   want;
    } row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // travels with the offered word: a typed-in expectation, if any
    logic        drv_typed = 1'b0;
    slot_out_t   drv_want  = '0;

    audio_underrun_fade_out_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // fade predictor state
    logic run_on;
    int   slot_pos;
    logic in_fade;
    int   fade_len;
    int   fade_idx;
    int   keep_left;
    int   keep_right;
    int   pend_left;

    slot_out_t slots_due [$];
    int        mismatches = 0;
    int        words_in   = 0;
    int        words_out  = 0;
    int        block_ends = 0;
    int        fade_slots = 0;

    int         tx_gap_pct   = 0;
    int         rx_stall_pct = 0;
    logic       hold_rx      = 1'b0;
    int         hold_count   = 0;
    int         stuck        = 0;
    int         gen_pos      = 0;
    int         miss_at      = SLOTS;
    logic       noisy_block  = 1'b0;

    row_t script [0:17] = '{
        '{ROW_WORD, 16'h7FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h8000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_RUN,  16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h7FFF, 1'b1, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h8000, 1'b1, 1'b1, '{16'h8000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h5555, 1'b1, 1'b1, '{16'h5555, 1'b0, 1'b0}},
        '{ROW_WORD, 16'hAAAA, 1'b1, 1'b1, '{16'hAAAA, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h1234, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h7FFF, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h8000, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h4321, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_RUN,  16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h7FFF, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_RUN,  16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h8000, 1'b1, 1'b1, '{16'h8000, 1'b0, 1'b0}},
        '{ROW_WORD, 16'h0001, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}}
    };

    function automatic void clear_fade_state();
        slot_pos   = 0;
        in_fade    = 1'b0;
        fade_len   = 0;
        fade_idx   = 0;
        keep_left  = 0;
        keep_right = 0;
        pend_left  = 0;
    endfunction

    function automatic slot_out_t predict_slot(input logic [15:0] d, input logic supplied);
        slot_out_t r;
        int        v;
        int        base;
        r = '0;
        if (!run_on) begin
            clear_fade_state();
            return r;
        end
        if (!in_fade && !supplied) begin
            in_fade  = 1'b1;
            fade_len = (SLOTS - slot_pos) / 2;
            fade_idx = 0;
        end
        if (in_fade) begin
            if (fade_len == 0 || fade_idx >= 2 * fade_len) begin
                v = 0;
            end else begin
                base = fade_idx[0] ? keep_right : keep_left;
                v = (base * (fade_len - fade_idx / 2)) / fade_len;
            end
            fade_idx++;
        end else begin
            v = int'($signed(d));
        end
        if (slot_pos == SLOTS - 2)
            pend_left = v;
        r.sample = v[15:0];
        r.fade   = in_fade;
        r.last   = (slot_pos >= SLOTS - 1);
        if (r.last) begin
            keep_left  = pend_left;
            keep_right = v;
            slot_pos   = 0;
            in_fade    = 1'b0;
            fade_len   = 0;
            fade_idx   = 0;
            pend_left  = 0;
        end else begin
            slot_pos++;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at word %0d: %s got %0h want %0h", words_out, what, got, want);
        mismatches++;
    endtask

    // predict on accepted input, check on accepted output
    always @(posedge aclk) begin
        slot_out_t want;
        if (!aresetn) begin
            run_on = 1'b0;
            clear_fade_state();
        end else begin
            if (cfg_we) begin
                run_on = cfg_wdata;
                if (!run_on)
                    clear_fade_state();
            end
            if (s_tvalid && s_tready) begin
                want = predict_slot(s_tdata, s_tuser);
                if (drv_typed)
                    want = drv_want;
                slots_due.push_back(want);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                if (slots_due.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, 0);
                end else begin
                    want = slots_due.pop_front();
                    if (m_tdata !== want.sample)
                        report_mismatch("sample_out", m_tdata, want.sample);
                    if (m_tuser !== want.fade)
                        report_mismatch("is_fade", m_tuser, want.fade);
                    if (m_tlast !== want.last)
                        report_mismatch("block_end", m_tlast, want.last);
                end
                if (m_tlast === 1'b1)
                    block_ends++;
                if (m_tuser === 1'b1)
                    fade_slots++;
                words_out++;
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_rx && hold_count < HOLD_CYCLES) begin
            hold_count++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stuck = 0;
        else
            stuck++;
        if (stuck == STUCK_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_word(input logic [15:0] d, input logic u, input logic typed,
                             input slot_out_t want);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < tx_gap_pct)
                @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= d;
        s_tuser   <= u;
        drv_typed <= typed;
        drv_want  <= want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // drop valid and let the word accepted at this edge be queued before waiting for the queue to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (slots_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_running(input logic v);
        settle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // supplied up to a first missing slot, then random flags; one block in eight is random throughout
    task automatic feed_slots(input int count, input logic with_hold);
        logic [15:0] d;
        logic        u;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == HOLD_AFTER)
                hold_rx = 1'b1;
            if (gen_pos == 0) begin
                noisy_block = ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 7))
                    0, 1: miss_at = SLOTS;
                    2: miss_at = 0;
                    3: miss_at = SLOTS - 1;
                    4: miss_at = SLOTS - 2;
                    5: miss_at = SLOTS - 3;
                    default: miss_at = $urandom_range(1, SLOTS - 4);
                endcase
            end
            case ($urandom_range(0, 7))
                0: d = 16'h7FFF;
                1: d = 16'h8000;
                2: d = 16'(int'($urandom_range(0, 6)) - 3);
                default: d = 16'($urandom);
            endcase
            if (noisy_block)
                u = 1'($urandom_range(0, 1));
            else if (gen_pos < miss_at)
                u = 1'b1;
            else if (gen_pos == miss_at)
                u = 1'b0;
            else
                u = 1'($urandom_range(0, 1));
            push_word(d, u, 1'b0, '0);
            gen_pos = (gen_pos + 1) % SLOTS;
        end
    endtask

    initial begin
        idle_mode_e mode;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_RUN)
                write_running(script[i].data[0]);
            else
                push_word(script[i].data, script[i].user, script[i].typed, script[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            mode = idle_mode_e'(p);
            case (mode)
                IDLE_NONE: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                IDLE_TX:   begin tx_gap_pct = 77; rx_stall_pct = 0;  end
                IDLE_RX:   begin tx_gap_pct = 0;  rx_stall_pct = 77; end
                default:   begin tx_gap_pct = 20; rx_stall_pct = 20; end
            endcase
            if (p % 2 == 0) begin
                // stop mid-block, feed random words that must come out as zeros, restart from a clean block
                write_running(1'b0);
                repeat (STOPPED_WORDS)
                    push_word(16'($urandom), 1'($urandom), 1'b1, '0);
                write_running(1'b1);
                gen_pos = 0;
            end else begin
                write_running(1'b1);
            end
            feed_slots(PHASE_WORDS, mode == IDLE_NONE);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d words in, %0d out, %0d block ends, %0d fade slots",
                 words_in, words_out, block_ends, fade_slots);
        $display("idle phases: none, sender, receiver, both; one long receiver hold");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/auf_pkg.sv
hw/rtl/auf_ctrl.sv
hw/rtl/auf_datapath.sv
hw/rtl/audio_underrun_fade_out_top.sv
dv/audio_underrun_fade_out_top_tb.sv
